[src/rtmq_pkg.sv]
// Shared types and codes for the rotation matrix to quaternion unit.
// No dependencies; the quaternion channel, the divider and the top level use this package.
package rtmq_pkg;

	typedef logic [1:0] branch_t;

	localparam branch_t BR_TRACE = 2'd0;
	localparam branch_t BR_X     = 2'd1;
	localparam branch_t BR_Y     = 2'd2;
	localparam branch_t BR_Z     = 2'd3;

	localparam int NUM_LANES = 3;

endpackage

[src/rtmq_mat_if.sv]
// Valid/ready channel that carries one 3x3 matrix per beat.
// Depends on nothing but its width parameter.
interface rtmq_mat_if #(parameter int W = 16) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
	modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

[src/rtmq_quat_if.sv]
// Valid/ready channel that carries one quaternion and its branch code per beat.
// Depends on rtmq_pkg for the branch type.
interface rtmq_quat_if #(parameter int W = 16) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] q_real, q_x, q_y, q_z;
	rtmq_pkg::branch_t branch_taken;

	modport source(output valid, q_real, q_x, q_y, q_z, branch_taken, input ready);
	modport sink(input valid, q_real, q_x, q_y, q_z, branch_taken, output ready);
endinterface

[src/rtmq_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per register stage.
// Stand-alone; the caller supplies the shared stage enable.
module rtmq_sqrt_pipe #(
	parameter int HW = 16,
	parameter int TW = 8
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*HW-1:0] rad,
	input  logic [TW-1:0]   tag_in,
	output logic [HW-1:0]   root,
	output logic [TW-1:0]   tag_out
);
	logic [HW+1:0]   rem_s  [HW];
	logic [HW-1:0]   root_s [HW];
	logic [2*HW-1:0] rad_s  [HW];
	logic [TW-1:0]   tag_s  [HW];

	for (genvar i = 0; i < HW; i++) begin : g_stage
		logic [HW+1:0]   rem_p;
		logic [HW-1:0]   root_p;
		logic [2*HW-1:0] rad_p;
		logic [TW-1:0]   tag_p;
		logic [HW+3:0]   sh, trial, diff;
		logic            ge;

		if (i == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
			assign tag_p  = tag_in;
		end else begin : g_next
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign rad_p  = rad_s[i-1];
			assign tag_p  = tag_s[i-1];
		end

		always_comb begin
			sh    = {rem_p, rad_p[2*HW-1 -: 2]};
			trial = {2'b00, root_p, 2'b01};
			ge    = sh >= trial;
			diff  = sh - trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? diff[HW+1:0] : sh[HW+1:0];
				root_s[i] <= {root_p[HW-2:0], ge};
				rad_s[i]  <= rad_p << 2;
				tag_s[i]  <= tag_p;
			end
		end
	end

	assign root    = root_s[HW-1];
	assign tag_out = tag_s[HW-1];
endmodule

[src/rtmq_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor. Depends on rtmq_pkg for the lane count.
module rtmq_div_pipe #(
	parameter int DW = 31,
	parameter int VW = 17,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] dend [rtmq_pkg::NUM_LANES],
	input  logic [VW-1:0] dv,
	input  logic [TW-1:0] tag_in,
	output logic [DW-1:0] quo  [rtmq_pkg::NUM_LANES],
	output logic [TW-1:0] tag_out
);
	import rtmq_pkg::*;

	logic [VW-1:0] rem_s [DW][NUM_LANES];
	logic [DW-1:0] dq_s  [DW][NUM_LANES];
	logic [VW-1:0] dv_s  [DW];
	logic [TW-1:0] tag_s [DW];

	for (genvar i = 0; i < DW; i++) begin : g_stage
		logic [VW-1:0] dv_p;
		logic [TW-1:0] tag_p;

		if (i == 0) begin : g_first
			assign dv_p  = dv;
			assign tag_p = tag_in;
		end else begin : g_next
			assign dv_p  = dv_s[i-1];
			assign tag_p = tag_s[i-1];
		end

		for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
			logic [VW-1:0] rem_p;
			logic [DW-1:0] dq_p;
			logic [VW:0]   sh, diff;
			logic          ge;

			if (i == 0) begin : g_first
				assign rem_p = '0;
				assign dq_p  = dend[l];
			end else begin : g_next
				assign rem_p = rem_s[i-1][l];
				assign dq_p  = dq_s[i-1][l];
			end

			always_comb begin
				sh   = {rem_p, dq_p[DW-1]};
				ge   = sh >= {1'b0, dv_p};
				diff = sh - {1'b0, dv_p};
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i][l] <= ge ? diff[VW-1:0] : sh[VW-1:0];
					dq_s[i][l]  <= {dq_p[DW-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[i]  <= dv_p;
				tag_s[i] <= tag_p;
			end
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
		assign quo[l] = dq_s[DW-1][l];
	end

	assign tag_out = tag_s[DW-1];
endmodule

[src/rotation_matrix_to_quaternion_unit.sv]
// Rotation matrix to quaternion converter, four-way branch on the diagonal.
// The pipeline is one decode stage, one stage per root bit of the square root,
// one operand stage, one stage per quotient bit of the divider and an output
// register. One beat is taken every cycle; a stalled output holds the whole
// pipeline. arst_n clears the valid bits only.
// Depends on rtmq_pkg, the channel interfaces, rtmq_sqrt_pipe and rtmq_div_pipe.
module rotation_matrix_to_quaternion_unit #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input logic clk,
	input logic arst_n,
	rtmq_mat_if.sink    mat,
	rtmq_quat_if.source quat
);
	import rtmq_pkg::*;

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int RW  = ((F > W) ? F : W) + 3;
	localparam int RS  = RW + 1;
	localparam int SI  = RW + F - 2;
	localparam int HW  = (SI + (SI % 2)) / 2;
	localparam int DW  = ((W + F > HW) ? W + F : HW) + 1;
	localparam int VW  = HW + 1;
	localparam int N   = HW + DW + 3;
	localparam int NW  = W + 1;
	localparam int STW = 2 + NUM_LANES * NW;
	localparam int DTW = 2 + NUM_LANES + HW;
	localparam logic [63:0] QMAX = (64'd1 << (W - 1)) - 64'd1;
	localparam logic signed [RS-1:0] ONE = RS'(64'd1 << F);

	logic [N-1:0] vld_q;
	logic         en;

	assign en        = !vld_q[N-1] || quat.ready;
	assign mat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N-2:0], mat.valid};
		end
	end

	logic signed [RS-1:0] e00, e11, e22, tr, radv;
	logic signed [NW-1:0] x01, x02, x10, x12, x20, x21;
	logic signed [NW-1:0] n_c [NUM_LANES];
	branch_t              br_c;

	always_comb begin
		e00 = {{(RS-W){mat.m00[W-1]}}, mat.m00};
		e11 = {{(RS-W){mat.m11[W-1]}}, mat.m11};
		e22 = {{(RS-W){mat.m22[W-1]}}, mat.m22};
		x01 = {mat.m01[W-1], mat.m01};
		x02 = {mat.m02[W-1], mat.m02};
		x10 = {mat.m10[W-1], mat.m10};
		x12 = {mat.m12[W-1], mat.m12};
		x20 = {mat.m20[W-1], mat.m20};
		x21 = {mat.m21[W-1], mat.m21};
		tr  = e00 + e11 + e22;
		if (!tr[RS-1]) begin
			br_c   = BR_TRACE;
			radv   = ONE + tr;
			n_c[0] = x21 - x12;
			n_c[1] = x02 - x20;
			n_c[2] = x10 - x01;
		end else if (e00 > e11 && e00 > e22) begin
			br_c   = BR_X;
			radv   = ONE + e00 - e11 - e22;
			n_c[0] = x21 - x12;
			n_c[1] = x01 + x10;
			n_c[2] = x02 + x20;
		end else if (e11 > e22) begin
			br_c   = BR_Y;
			radv   = ONE + e11 - e00 - e22;
			n_c[0] = x02 - x20;
			n_c[1] = x01 + x10;
			n_c[2] = x12 + x21;
		end else begin
			br_c   = BR_Z;
			radv   = ONE + e22 - e00 - e11;
			n_c[0] = x10 - x01;
			n_c[1] = x02 + x20;
			n_c[2] = x12 + x21;
		end
		if (radv < RS'(1)) begin
			radv = RS'(1);
		end
	end

	logic [RW-1:0] rad_s1;
	logic [STW-1:0] tag_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= radv[RW-1:0];
			tag_s1 <= {br_c, n_c[0], n_c[1], n_c[2]};
		end
	end

	logic [HW-1:0]  root;
	logic [STW-1:0] sq_tag;

	rtmq_sqrt_pipe #(.HW(HW), .TW(STW)) u_sqrt (
		.clk     (clk),
		.en      (en),
		.rad     ((2 * HW)'(rad_s1) << (F - 2)),
		.tag_in  (tag_s1),
		.root    (root),
		.tag_out (sq_tag)
	);

	logic [HW-1:0]        hfix;
	logic signed [NW-1:0] n_p [NUM_LANES];
	logic [NW-1:0]        mag [NUM_LANES];
	logic [NUM_LANES-1:0] sgn;
	logic [DW-1:0]        dend_c [NUM_LANES];

	always_comb begin
		hfix   = (root == '0) ? HW'(1) : root;
		n_p[0] = sq_tag[3*NW-1 -: NW];
		n_p[1] = sq_tag[2*NW-1 -: NW];
		n_p[2] = sq_tag[NW-1 -: NW];
		for (int l = 0; l < NUM_LANES; l++) begin
			sgn[l]    = n_p[l][NW-1];
			mag[l]    = sgn[l] ? (~n_p[l] + NW'(1)) : n_p[l];
			dend_c[l] = (DW'(mag[l]) << (F - 1)) + DW'(hfix);
		end
	end

	logic [DW-1:0]  dend_s2 [NUM_LANES];
	logic [VW-1:0]  dv_s2;
	logic [DTW-1:0] tag_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dend_s2 <= dend_c;
			dv_s2   <= {hfix, 1'b0};
			tag_s2  <= {sq_tag[STW-1 -: 2], sgn, hfix};
		end
	end

	logic [DW-1:0]  quo [NUM_LANES];
	logic [DTW-1:0] dv_tag;

	rtmq_div_pipe #(.DW(DW), .VW(VW), .TW(DTW)) u_div (
		.clk     (clk),
		.en      (en),
		.dend    (dend_s2),
		.dv      (dv_s2),
		.tag_in  (tag_s2),
		.quo     (quo),
		.tag_out (dv_tag)
	);

	function automatic logic [W-1:0] sat_q(input logic [DW-1:0] q, input logic neg);
		logic [DW-1:0] t;
		t = ~q + DW'(1);
		if (!neg) begin
			return (64'(q) > QMAX) ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
		end
		return (64'(q) > QMAX + 64'd1) ? {1'b1, {(W-1){1'b0}}} : t[W-1:0];
	endfunction

	branch_t              br_o;
	logic [NUM_LANES-1:0] sgn_o;
	logic [HW-1:0]        h_o;
	logic [W-1:0]         hs, l0, l1, l2;
	logic [W-1:0]         qr_c, qx_c, qy_c, qz_c;

	always_comb begin
		br_o  = dv_tag[DTW-1 -: 2];
		sgn_o = dv_tag[HW+NUM_LANES-1 -: NUM_LANES];
		h_o   = dv_tag[HW-1:0];
		hs    = (64'(h_o) > QMAX) ? {1'b0, {(W-1){1'b1}}} : W'(h_o);
		l0    = sat_q(quo[0], sgn_o[0]);
		l1    = sat_q(quo[1], sgn_o[1]);
		l2    = sat_q(quo[2], sgn_o[2]);
		unique case (br_o)
			BR_TRACE: begin
				qr_c = hs; qx_c = l0; qy_c = l1; qz_c = l2;
			end
			BR_X: begin
				qr_c = l0; qx_c = hs; qy_c = l1; qz_c = l2;
			end
			BR_Y: begin
				qr_c = l0; qx_c = l1; qy_c = hs; qz_c = l2;
			end
			default: begin
				qr_c = l0; qx_c = l1; qy_c = l2; qz_c = hs;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat.q_real       <= qr_c;
			quat.q_x          <= qx_c;
			quat.q_y          <= qy_c;
			quat.q_z          <= qz_c;
			quat.branch_taken <= br_o;
		end
	end

	assign quat.valid = vld_q[N-1];

	a_accept_enters : assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.ready |=> vld_q[0])
		else $error("accepted beat did not enter the pipeline");

	a_ready_when_free : assert property (@(posedge clk) disable iff (!arst_n)
		!quat.valid |-> mat.ready)
		else $error("input stalled while the output stage is empty");

	a_trace_real_pos : assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.branch_taken == BR_TRACE |-> !quat.q_real[W-1])
		else $error("diagonal component of trace branch is negative");
endmodule
